// ===== rtl/core/ptm_pkg.sv =====
`default_nettype none

package ptm_pkg;

    // Field widths of the stream items
    localparam int RATE_W    = 18;
    localparam int VOL_W     = 8;
    localparam int SAMP_W    = 16;
    localparam int IDX_W     = 10;
    localparam int BUFF_W    = 11;
    localparam int CMD_W     = 2;

    // Bus widths
    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 32;
    localparam int APB_AW      = 4;
    localparam int APB_DW      = 32;

    // Divider iteration counter
    localparam int DIV_CNT_W = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_BEGIN = 2'd0,
        CMD_FRAME = 2'd1,
        CMD_READ  = 2'd2
    } t_cmd;

    // Controller to datapath
    typedef struct packed {
        logic latch;
        logic clr_step;
        logic beg_load;
        logic div_start;
        logic dec_load;
        logic rep_load;
        logic fr_eval;
        logic fr_mix;
        logic fr_sum;
        logic fr_write;
        logic rd_issue;
        logic out_load;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clr_last;
        logic div_done;
        logic fr_skip;
        logic fr_last;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== rtl/core/ptm_ram.sv =====
`default_nettype none

module ptm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read-first: a read and write to the same address return the old word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/core/ptm_div.sv =====
`default_nettype none

module ptm_div
    import ptm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [RATE_W-1:0] i_num,
    input  wire logic [RATE_W-1:0] i_den,
    output logic                   o_done,
    output logic      [RATE_W-1:0] o_quot
);

    logic [RATE_W-1:0]    r_quot;
    logic [RATE_W-1:0]    r_den;
    logic [RATE_W:0]      r_rem;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [RATE_W:0] shifted;
    logic [RATE_W:0] diff;

    // restoring division, one quotient bit per cycle
    assign shifted = {r_rem[RATE_W-1:0], r_quot[RATE_W-1]};
    assign diff    = shifted - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_quot <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_cnt  <= DIV_CNT_W'(RATE_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (!diff[RATE_W]) begin
                    r_rem  <= diff;
                    r_quot <= {r_quot[RATE_W-2:0], 1'b1};
                end else begin
                    r_rem  <= shifted;
                    r_quot <= {r_quot[RATE_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

// ===== rtl/core/ptm_datapath.sv =====
`default_nettype none

module ptm_datapath
    import ptm_pkg::*;
#(
    parameter int FRAMES = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_dp_cmd                  i_dp_cmd,
    output t_dp_sts                       o_dp_sts,
    input  wire logic                     i_source_stereo,
    input  wire logic [RATE_W-1:0]        i_source_rate,
    input  wire logic [VOL_W-1:0]         i_track_volume,
    input  wire logic [VOL_W-1:0]         i_sound_volume,
    input  wire logic signed [SAMP_W-1:0] i_left_sample,
    input  wire logic signed [SAMP_W-1:0] i_right_sample,
    input  wire logic [IDX_W-1:0]         i_frame_index,
    input  wire logic [RATE_W-1:0]        i_device_rate,
    input  wire logic                     i_device_stereo,
    input  wire logic [BUFF_W-1:0]        i_buffer_frames,
    input  wire logic                     i_out_ready,
    output logic                          o_out_valid,
    output logic signed [SAMP_W-1:0]      o_out_left,
    output logic signed [SAMP_W-1:0]      o_out_right
);

    localparam int AW   = $clog2(FRAMES);
    localparam int WPW  = $clog2(FRAMES + 1);
    localparam int PW   = SAMP_W + VOL_W + 1;
    localparam logic signed [SAMP_W:0] LIM_HI = 17'sd32765;
    localparam logic signed [SAMP_W:0] LIM_LO = -17'sd32765;

    function automatic logic signed [SAMP_W-1:0] clamp_amp(input logic signed [SAMP_W:0] v);
        logic signed [SAMP_W:0] c;
        begin
            if (v > LIM_HI) begin
                c = LIM_HI;
            end else if (v < LIM_LO) begin
                c = LIM_LO;
            end else begin
                c = v;
            end
            return c[SAMP_W-1:0];
        end
    endfunction

    // latched item
    logic                     r_src_stereo;
    logic [RATE_W-1:0]        r_src_rate;
    logic [VOL_W-1:0]         r_tv;
    logic [VOL_W-1:0]         r_sv;
    logic signed [SAMP_W-1:0] r_left;
    logic signed [SAMP_W-1:0] r_right;
    logic [IDX_W-1:0]         r_idx;

    // track state
    logic [VOL_W-1:0]  r_gain;
    logic              r_trk_stereo;
    logic [RATE_W-1:0] r_dec;
    logic [RATE_W-1:0] r_rep;
    logic [RATE_W-1:0] r_stride;
    logic [RATE_W-1:0] r_rep_cnt;
    logic [WPW-1:0]    r_wp;
    logic [AW-1:0]     r_clr_cnt;

    // mixing pipeline
    logic signed [PW-1:0]     r_pl;
    logic signed [PW-1:0]     r_pr;
    logic signed [SAMP_W-1:0] r_al;
    logic signed [SAMP_W-1:0] r_ar;
    logic signed [SAMP_W-1:0] r_dl;
    logic signed [SAMP_W-1:0] r_dr;

    logic                     r_out_valid;
    logic signed [SAMP_W-1:0] r_out_l;
    logic signed [SAMP_W-1:0] r_out_r;

    // gain = floor(tv*sv/255) via reciprocal, exact for 16-bit products
    logic [2*VOL_W-1:0] vol_prod;
    logic [2*VOL_W-1:0] gain_sum;
    assign vol_prod = r_tv * r_sv;
    assign gain_sum = vol_prod + {{VOL_W{1'b0}}, vol_prod[2*VOL_W-1:VOL_W]} + 16'd1;

    // rate steps, zero rate taken as one
    logic [RATE_W-1:0] src_rate_e;
    logic [RATE_W-1:0] dev_rate_e;
    logic [RATE_W-1:0] div_num;
    logic [RATE_W-1:0] div_den;
    logic [RATE_W-1:0] div_quot;
    logic [RATE_W-1:0] quot_fix;
    logic              div_done;

    assign src_rate_e = (r_src_rate == '0) ? RATE_W'(1) : r_src_rate;
    assign dev_rate_e = (i_device_rate == '0) ? RATE_W'(1) : i_device_rate;
    assign div_num    = i_dp_cmd.beg_load ? src_rate_e : dev_rate_e;
    assign div_den    = i_dp_cmd.beg_load ? dev_rate_e : src_rate_e;
    assign quot_fix   = (div_quot == '0) ? RATE_W'(1) : div_quot;

    ptm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_dp_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // fill limit = min(buffer_frames, FRAMES)
    logic [WPW-1:0] limit;
    always_comb begin
        if (32'(i_buffer_frames) < FRAMES) begin
            limit = WPW'(i_buffer_frames);
        end else begin
            limit = WPW'(FRAMES);
        end
    end

    logic            keep;
    logic [RATE_W:0] stride_inc;
    logic [RATE_W:0] rep_inc;
    logic [WPW:0]    wp_inc;
    logic            full;

    assign keep       = (r_stride == '0);
    assign stride_inc = {1'b0, r_stride} + 1'b1;
    assign rep_inc    = {1'b0, r_rep_cnt} + 1'b1;
    assign wp_inc     = {1'b0, r_wp} + 1'b1;
    assign full       = (r_wp >= limit);

    // scaled samples: arithmetic shift floors
    logic signed [SAMP_W-1:0] scaled_l;
    logic signed [SAMP_W-1:0] scaled_r;
    logic signed [SAMP_W:0]   sum_lr;
    logic [SAMP_W:0]          sum_adj;
    logic signed [SAMP_W-1:0] mean_lr;

    assign scaled_l = r_pl[SAMP_W+VOL_W-1:VOL_W];
    assign scaled_r = r_pr[SAMP_W+VOL_W-1:VOL_W];
    assign sum_lr   = scaled_l + scaled_r;
    // bias negatives by one so the halving truncates toward zero
    assign sum_adj  = sum_lr + {{SAMP_W{1'b0}}, sum_lr[SAMP_W]};
    assign mean_lr  = sum_adj[SAMP_W:1];

    // frame buffer
    logic [AW-1:0]            ram_addr;
    logic                     ram_re;
    logic                     we_l;
    logic                     we_r;
    logic [SAMP_W-1:0]        wd_l;
    logic [SAMP_W-1:0]        wd_r;
    logic [SAMP_W-1:0]        q_l;
    logic [SAMP_W-1:0]        q_r;
    logic signed [SAMP_W-1:0] buf_l;
    logic signed [SAMP_W-1:0] buf_r;
    logic signed [SAMP_W:0]   tot_l;
    logic signed [SAMP_W:0]   tot_r;
    logic [IDX_W+AW-1:0]      idx_ext;
    logic                     in_range;
    logic                     both;

    assign idx_ext  = {{AW{1'b0}}, r_idx};
    assign in_range = (32'(r_idx) < FRAMES);
    assign both     = r_trk_stereo & i_device_stereo;
    assign buf_l    = q_l;
    assign buf_r    = q_r;
    assign tot_l    = buf_l + r_al;
    assign tot_r    = buf_r + r_ar;

    always_comb begin
        if (i_dp_cmd.clr_step) begin
            ram_addr = r_clr_cnt;
        end else if (i_dp_cmd.rd_issue) begin
            ram_addr = idx_ext[AW-1:0];
        end else begin
            ram_addr = r_wp[AW-1:0];
        end
    end

    assign ram_re = i_dp_cmd.rd_issue | i_dp_cmd.fr_eval;
    assign we_l   = i_dp_cmd.clr_step | (i_dp_cmd.rd_issue & in_range) | i_dp_cmd.fr_write;
    assign we_r   = i_dp_cmd.clr_step | (i_dp_cmd.rd_issue & in_range)
                  | (i_dp_cmd.fr_write & i_device_stereo);
    assign wd_l   = i_dp_cmd.fr_write ? r_dl : '0;
    assign wd_r   = i_dp_cmd.fr_write ? r_dr : '0;

    ptm_ram #(
        .WIDTH (SAMP_W),
        .DEPTH (FRAMES)
    ) u_ram_left (
        .i_clk   (i_clk),
        .i_we    (we_l),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (wd_l),
        .o_rdata (q_l)
    );

    ptm_ram #(
        .WIDTH (SAMP_W),
        .DEPTH (FRAMES)
    ) u_ram_right (
        .i_clk   (i_clk),
        .i_we    (we_r),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (wd_r),
        .o_rdata (q_r)
    );

    // item latch
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.latch) begin
            r_src_stereo <= i_source_stereo;
            r_src_rate   <= i_source_rate;
            r_tv         <= i_track_volume;
            r_sv         <= i_sound_volume;
            r_left       <= i_left_sample;
            r_right      <= i_right_sample;
            r_idx        <= i_frame_index;
        end
    end

    // mixing pipeline registers
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.fr_eval) begin
            r_pl <= r_left * $signed({1'b0, r_gain});
            r_pr <= r_right * $signed({1'b0, r_gain});
        end
        if (i_dp_cmd.fr_mix) begin
            r_al <= (r_trk_stereo && !i_device_stereo) ? mean_lr : scaled_l;
            r_ar <= scaled_r;
        end
        if (i_dp_cmd.fr_sum) begin
            r_dl <= clamp_amp(tot_l);
            r_dr <= both ? clamp_amp(tot_r) : clamp_amp(tot_l);
        end
    end

    // track state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain       <= '0;
            r_trk_stereo <= 1'b0;
            r_dec        <= RATE_W'(1);
            r_rep        <= RATE_W'(1);
            r_stride     <= '0;
            r_rep_cnt    <= '0;
            r_wp         <= '0;
            r_clr_cnt    <= '0;
        end else begin
            if (i_dp_cmd.clr_step) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (i_dp_cmd.beg_load) begin
                r_gain       <= gain_sum[2*VOL_W-1:VOL_W];
                r_trk_stereo <= r_src_stereo;
                r_wp         <= '0;
                r_stride     <= '0;
            end
            if (i_dp_cmd.dec_load) begin
                r_dec <= quot_fix;
            end
            if (i_dp_cmd.rep_load) begin
                r_rep <= quot_fix;
            end
            if (i_dp_cmd.fr_eval && (r_gain != '0)) begin
                if (stride_inc >= {1'b0, r_dec}) begin
                    r_stride <= '0;
                end else begin
                    r_stride <= stride_inc[RATE_W-1:0];
                end
            end
            if (i_dp_cmd.fr_sum) begin
                r_rep_cnt <= '0;
            end
            if (i_dp_cmd.fr_write) begin
                r_wp      <= wp_inc[WPW-1:0];
                r_rep_cnt <= rep_inc[RATE_W-1:0];
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_dp_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.out_load) begin
            r_out_l <= in_range ? buf_l : '0;
            r_out_r <= (in_range && i_device_stereo) ? buf_r : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_left  = r_out_l;
    assign o_out_right = r_out_r;

    assign o_dp_sts.clr_last = (r_clr_cnt == AW'(FRAMES - 1));
    assign o_dp_sts.div_done = div_done;
    assign o_dp_sts.fr_skip  = (r_gain == '0) | !keep | full;
    assign o_dp_sts.fr_last  = (rep_inc >= {1'b0, r_rep}) | (wp_inc >= {1'b0, limit});
    assign o_dp_sts.out_free = !r_out_valid | i_out_ready;

endmodule

`default_nettype wire

// ===== rtl/core/ptm_ctrl.sv =====
`default_nettype none

module ptm_ctrl
    import ptm_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic [CMD_W-1:0] i_cmd,
    output logic                  o_in_ready,
    input  wire t_dp_sts          i_dp_sts,
    output t_dp_cmd               o_dp_cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_BEG,
        S_DIV0,
        S_BEG2,
        S_DIV1,
        S_FR_EVAL,
        S_FR_MIX,
        S_FR_SUM,
        S_FR_WR,
        S_RD_WAIT,
        S_RD_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_ready;
    logic   accept;

    assign accept = i_in_valid & r_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_dp_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    unique case (i_cmd)
                        CMD_BEGIN: n_state = S_BEG;
                        CMD_FRAME: n_state = S_FR_EVAL;
                        CMD_READ:  n_state = S_RD_WAIT;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_BEG:     n_state = S_DIV0;
            S_DIV0: begin
                if (i_dp_sts.div_done) n_state = S_BEG2;
            end
            S_BEG2:    n_state = S_DIV1;
            S_DIV1: begin
                if (i_dp_sts.div_done) n_state = S_IDLE;
            end
            S_FR_EVAL: n_state = i_dp_sts.fr_skip ? S_IDLE : S_FR_MIX;
            S_FR_MIX:  n_state = S_FR_SUM;
            S_FR_SUM:  n_state = S_FR_WR;
            S_FR_WR: begin
                if (i_dp_sts.fr_last) n_state = S_IDLE;
            end
            S_RD_WAIT: begin
                if (i_dp_sts.out_free) n_state = S_RD_OUT;
            end
            S_RD_OUT:  n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= (n_state == S_IDLE);
        end
    end

    always_comb begin
        o_dp_cmd           = '0;
        o_dp_cmd.latch     = accept;
        o_dp_cmd.clr_step  = (r_state == S_CLEAR);
        o_dp_cmd.beg_load  = (r_state == S_BEG);
        o_dp_cmd.div_start = (r_state == S_BEG) || (r_state == S_BEG2);
        o_dp_cmd.dec_load  = (r_state == S_DIV0) && i_dp_sts.div_done;
        o_dp_cmd.rep_load  = (r_state == S_DIV1) && i_dp_sts.div_done;
        o_dp_cmd.fr_eval   = (r_state == S_FR_EVAL);
        o_dp_cmd.fr_mix    = (r_state == S_FR_MIX);
        o_dp_cmd.fr_sum    = (r_state == S_FR_SUM);
        o_dp_cmd.fr_write  = (r_state == S_FR_WR);
        o_dp_cmd.rd_issue  = (r_state == S_RD_WAIT) && i_dp_sts.out_free;
        o_dp_cmd.out_load  = (r_state == S_RD_OUT);
    end

    assign o_in_ready = r_ready;

endmodule

`default_nettype wire

// ===== rtl/core/pcm_track_mixer_unit.sv =====
// PCM track mixer: tracks are summed one after another into a stored frame
// buffer (left and right, 16-bit, saturating at +-32765), frames read back.
// Input stream (s_axis): tuser carries the command - begin track, source frame,
// read-and-clear frame. A begin item loads gain floor(tv*sv/255), channel
// count and the decimation / repeat steps and rewinds the write pointer.
// Output stream (m_axis): one item per read command, {right, left}.
// APB: device_rate @0x0, device_stereo @0x4, buffer_frames @0x8.
// Work per item, from input accept to next accept:
//   begin  two 18-bit divisions in the shared bit-serial divider
//   frame  skipped, or kept and written to n = min(repeat_step, frames
//          left below the fill limit) frames: one RAM write per cycle per output frame
//   read   reads and clears the frame; the result goes to the output register once it frees
// The block takes one item at a time. A result waiting in the output register
// does not block begin or frame items; a read item holds until that register
// frees, so a stalled receiver stalls only reads.
// Reset: synchronous; afterwards a clearing pass zeroes the buffer frame by
// frame, during which no item is accepted (APB writes are taken).
`default_nettype none

module pcm_track_mixer_unit
    import ptm_pkg::*;
#(
    parameter int FRAMES = 1024
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // input stream
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // [0] source_stereo, [18:1] source_rate, [26:19] track_volume,
    // [34:27] sound_volume, [50:35] left_sample, [66:51] right_sample,
    // [76:67] frame_index, [79:77] zero
    input  wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // [1:0] cmd
    input  wire logic [CMD_W-1:0]       i_s_axis_tuser,
    // result stream
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    // [15:0] out_left, [31:16] out_right
    output logic [OUT_TDATA_W-1:0]      o_m_axis_tdata,
    // configuration
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [APB_AW-1:0]      paddr,
    input  wire logic [APB_DW-1:0]      pwdata,
    output logic      [APB_DW-1:0]      prdata,
    output logic                        pready
);

    localparam logic [1:0] REG_DEVICE_RATE   = 2'd0;
    localparam logic [1:0] REG_DEVICE_STEREO = 2'd1;
    localparam logic [1:0] REG_BUFFER_FRAMES = 2'd2;

    localparam logic [RATE_W-1:0] RST_DEVICE_RATE   = 18'd44100;
    localparam logic              RST_DEVICE_STEREO = 1'b1;
    localparam logic [BUFF_W-1:0] RST_BUFFER_FRAMES = 11'd1024;

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [RATE_W-1:0] r_device_rate;
    logic              r_device_stereo;
    logic [BUFF_W-1:0] r_buffer_frames;
    logic              apb_wr;
    logic [1:0]        reg_idx;

    assign pready  = 1'b1;
    assign apb_wr  = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_rate   <= RST_DEVICE_RATE;
            r_device_stereo <= RST_DEVICE_STEREO;
            r_buffer_frames <= RST_BUFFER_FRAMES;
        end else if (apb_wr) begin
            unique case (reg_idx)
                REG_DEVICE_RATE:   r_device_rate   <= pwdata[RATE_W-1:0];
                REG_DEVICE_STEREO: r_device_stereo <= pwdata[0];
                REG_BUFFER_FRAMES: r_buffer_frames <= pwdata[BUFF_W-1:0];
                default: ;  // unmapped address, write dropped
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_DEVICE_RATE:   prdata = APB_DW'(r_device_rate);
            REG_DEVICE_STEREO: prdata = APB_DW'(r_device_stereo);
            REG_BUFFER_FRAMES: prdata = APB_DW'(r_buffer_frames);
            default:           prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // controller / datapath
    // ---------------------------------------------------------------
    t_dp_cmd                  dp_cmd;
    t_dp_sts                  dp_sts;
    logic                     out_valid;
    logic signed [SAMP_W-1:0] out_left;
    logic signed [SAMP_W-1:0] out_right;

    ptm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_cmd      (i_s_axis_tuser),
        .o_in_ready (o_s_axis_tready),
        .i_dp_sts   (dp_sts),
        .o_dp_cmd   (dp_cmd)
    );

    ptm_datapath #(
        .FRAMES (FRAMES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_dp_cmd        (dp_cmd),
        .o_dp_sts        (dp_sts),
        .i_source_stereo (i_s_axis_tdata[0]),
        .i_source_rate   (i_s_axis_tdata[18:1]),
        .i_track_volume  (i_s_axis_tdata[26:19]),
        .i_sound_volume  (i_s_axis_tdata[34:27]),
        .i_left_sample   (i_s_axis_tdata[50:35]),
        .i_right_sample  (i_s_axis_tdata[66:51]),
        .i_frame_index   (i_s_axis_tdata[76:67]),
        .i_device_rate   (r_device_rate),
        .i_device_stereo (r_device_stereo),
        .i_buffer_frames (r_buffer_frames),
        .i_out_ready     (i_m_axis_tready),
        .o_out_valid     (out_valid),
        .o_out_left      (out_left),
        .o_out_right     (out_right)
    );

    assign o_m_axis_tvalid = out_valid;
    assign o_m_axis_tdata  = {out_right, out_left};

endmodule

`default_nettype wire

// ===== rtl/core/ptm_chk.sv =====
`default_nettype none

module ptm_chk
    import ptm_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_s_tvalid,
    input wire logic                   i_s_tready,
    input wire logic [CMD_W-1:0]       i_s_tuser,
    input wire logic                   i_m_tvalid,
    input wire logic                   i_m_tready,
    input wire logic [OUT_TDATA_W-1:0] i_m_tdata
);

    logic s_acc;
    assign s_acc = i_s_tvalid & i_s_tready;

    // buffer clearing follows reset, so no item is taken right after it
    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_s_tready)
        else $error("input ready right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata))
        else $error("stalled result changed or dropped");

    // only read items produce results
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc && (i_s_tuser != CMD_READ) |=> !$rose(i_m_tvalid))
        else $error("result raised after a non-read item");

    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc && (i_s_tuser == CMD_READ) |=> !i_s_tready)
        else $error("input ready while a read is in progress");

endmodule

bind pcm_track_mixer_unit ptm_chk u_ptm_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_axis_tvalid),
    .i_s_tready (o_s_axis_tready),
    .i_s_tuser  (i_s_axis_tuser),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready),
    .i_m_tdata  (o_m_axis_tdata)
);

`default_nettype wire

// ===== verif/ptm_tb_pkg.sv =====
`timescale 1ns / 100ps

package ptm_tb_pkg;
    import ptm_pkg::*;

    // APB register map
    typedef enum logic [APB_AW-1:0] {
        REG_DEV_RATE   = 4'h0,
        REG_DEV_STEREO = 4'h4,
        REG_BUF_FRAMES = 4'h8
    } t_reg_addr;

    // tuser code outside the command set, the block drops it
    localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

    localparam int PAD_W = IN_TDATA_W - 1 - RATE_W - 2 * VOL_W - 2 * SAMP_W - IDX_W;

    // s_axis tdata layout, lowest field last
    typedef struct packed {
        logic [PAD_W-1:0]         pad;
        logic [IDX_W-1:0]         frame_index;
        logic signed [SAMP_W-1:0] right_sample;
        logic signed [SAMP_W-1:0] left_sample;
        logic [VOL_W-1:0]         sound_volume;
        logic [VOL_W-1:0]         track_volume;
        logic [RATE_W-1:0]        source_rate;
        logic                     source_stereo;
    } t_src_item;

    // m_axis tdata layout
    typedef struct packed {
        logic signed [SAMP_W-1:0] right;
        logic signed [SAMP_W-1:0] left;
    } t_mix_frame;

endpackage

// ===== verif/pcm_track_mixer_unit_checker.sv =====
`timescale 1ns / 100ps

module pcm_track_mixer_unit_checker
    import ptm_pkg::*;
    import ptm_tb_pkg::*;
#(
    parameter int FRAMES = 1024
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_tvalid,
    input  wire logic                   i_s_tready,
    input  wire logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  wire logic [CMD_W-1:0]       i_s_tuser,
    input  wire logic                   i_m_tvalid,
    input  wire logic                   i_m_tready,
    input  wire logic [OUT_TDATA_W-1:0] i_m_tdata,
    input  wire logic                   i_psel,
    input  wire logic                   i_penable,
    input  wire logic                   i_pwrite,
    input  wire logic                   i_pready,
    input  wire logic [APB_AW-1:0]      i_paddr,
    input  wire logic [APB_DW-1:0]      i_pwdata,
    output int                          o_mismatches,
    output int                          o_pending
);

    localparam int AMP_MAX = 32765;

    logic signed [SAMP_W-1:0] mix_l [FRAMES];
    logic signed [SAMP_W-1:0] mix_r [FRAMES];
    logic [BUFF_W-1:0]        wr_ptr;
    logic [VOL_W-1:0]         gain;
    logic                     trk_stereo;
    logic [RATE_W-1:0]        dec_step;
    logic [RATE_W-1:0]        rep_step;
    logic [RATE_W-1:0]        stride;
    logic [RATE_W-1:0]        dev_rate;
    logic                     dev_stereo;
    logic [BUFF_W-1:0]        buf_frames;

    t_mix_frame frames_due[$];
    int         mismatches;

    function automatic int scaled(logic signed [SAMP_W-1:0] s, logic [VOL_W-1:0] g);
        int p;
        p = int'(s) * int'({1'b0, g});
        return p >>> 8;                 // floor division by 256
    endfunction

    function automatic int clamp_amp(int v);
        if (v < -AMP_MAX) return -AMP_MAX;
        if (v > AMP_MAX) return AMP_MAX;
        return v;
    endfunction

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Updates the buffer model for one item; a read queues the frame it returns.
    task automatic mix_step(input logic [CMD_W-1:0] cmd, input t_src_item it);
        int         srate, drate, limit, n, l, r, a, dl, dr, idx;
        bit         keep;
        t_mix_frame fr;
        case (cmd)
            CMD_BEGIN: begin
                srate = (it.source_rate == 0) ? 1 : int'(it.source_rate);
                drate = (dev_rate == 0) ? 1 : int'(dev_rate);
                gain = VOL_W'((int'(it.track_volume) * int'(it.sound_volume)) / 255);
                trk_stereo = it.source_stereo;
                dec_step = (srate / drate == 0) ? 1 : RATE_W'(srate / drate);
                rep_step = (drate / srate == 0) ? 1 : RATE_W'(drate / srate);
                wr_ptr = '0;
                stride = '0;
            end
            CMD_FRAME: begin
                if (gain == 0) return;
                keep = (stride == 0);
                stride = stride + 1'b1;
                if (stride >= dec_step) stride = '0;
                if (!keep) return;
                limit = (int'(buf_frames) < FRAMES) ? int'(buf_frames) : FRAMES;
                if (int'(wr_ptr) >= limit) return;
                l = scaled(it.left_sample, gain);
                r = scaled(it.right_sample, gain);
                if (trk_stereo && dev_stereo) begin
                    dl = clamp_amp(int'(mix_l[wr_ptr]) + l);
                    dr = clamp_amp(int'(mix_r[wr_ptr]) + r);
                end else begin
                    a = trk_stereo ? (l + r) / 2 : l;     // truncates toward zero
                    dl = clamp_amp(int'(mix_l[wr_ptr]) + a);
                    dr = dl;
                end
                n = limit - int'(wr_ptr);
                if (int'(rep_step) < n) n = int'(rep_step);
                repeat (n) begin
                    mix_l[wr_ptr] = SAMP_W'(dl);
                    if (dev_stereo) mix_r[wr_ptr] = SAMP_W'(dr);
                    wr_ptr = wr_ptr + 1'b1;
                end
            end
            CMD_READ: begin
                idx = int'(it.frame_index);
                fr = '0;
                if (idx < FRAMES) begin
                    fr.left = mix_l[idx];
                    fr.right = dev_stereo ? mix_r[idx] : '0;
                    mix_l[idx] = '0;
                    mix_r[idx] = '0;
                end
                frames_due.push_back(fr);
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_mix_frame got, want;
        if (!i_rst_n) begin
            for (int i = 0; i < FRAMES; i++) begin
                mix_l[i] = '0;
                mix_r[i] = '0;
            end
            wr_ptr = '0;
            gain = '0;
            trk_stereo = 1'b0;
            dec_step = 1;
            rep_step = 1;
            stride = '0;
            dev_rate = 44100;
            dev_stereo = 1'b1;
            buf_frames = 1024;
            frames_due.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr)
                    REG_DEV_RATE:   dev_rate = i_pwdata[RATE_W-1:0];
                    REG_DEV_STEREO: dev_stereo = i_pwdata[0];
                    REG_BUF_FRAMES: buf_frames = i_pwdata[BUFF_W-1:0];
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata;
                if (frames_due.size() == 0) begin
                    note_mismatch($sformatf("result %h with nothing expected", i_m_tdata));
                end else begin
                    want = frames_due.pop_front();
                    if (got.left !== want.left)
                        note_mismatch($sformatf("out_left exp %0d got %0d",
                                                want.left, got.left));
                    if (got.right !== want.right)
                        note_mismatch($sformatf("out_right exp %0d got %0d",
                                                want.right, got.right));
                end
            end
            if (i_s_tvalid && i_s_tready) mix_step(i_s_tuser, i_s_tdata);
        end
        o_pending <= frames_due.size();
        o_mismatches <= mismatches;
    end

endmodule

// ===== verif/pcm_track_mixer_unit_test.sv =====
`timescale 1ns / 100ps

module pcm_track_mixer_unit_test;
    import ptm_pkg::*;
    import ptm_tb_pkg::*;

    localparam int FRAMES        = 1024;
    localparam int N_PHASES      = 8;
    localparam int RAND_ITEMS    = 1700;
    localparam int HOLD_CYCLES   = 400;     // long receiver hold-off
    localparam int SETTLE_CYCLES = 1100;    // begin divide plus a full-buffer repeat run
    localparam int STALL_LIMIT   = 20000;   // cycles with no handshake at all

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata;
    logic [CMD_W-1:0]       i_s_axis_tuser;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_AW-1:0]      paddr;
    logic [APB_DW-1:0]      pwdata;
    logic [APB_DW-1:0]      prdata;
    logic                   pready;

    int                     mismatches;
    int                     pending;
    int                     hold_req;       // bumped to ask the receiver for a hold-off
    int                     burst_left;
    int                     quiet_cycles;
    bit                     steady;         // no sender gaps while set
    logic [RATE_W-1:0]      cur_rate;       // device_rate as last written

    always #10 i_clk = ~i_clk;

    pcm_track_mixer_unit #(
        .FRAMES (FRAMES)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    pcm_track_mixer_unit_checker #(
        .FRAMES (FRAMES)
    ) u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_axis_tvalid),
        .i_s_tready   (o_s_axis_tready),
        .i_s_tdata    (i_s_axis_tdata),
        .i_s_tuser    (i_s_axis_tuser),
        .i_m_tvalid   (o_m_axis_tvalid),
        .i_m_tready   (i_m_axis_tready),
        .i_m_tdata    (o_m_axis_tdata),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    // ---------------------------------------------------------------
    // Field pickers
    // ---------------------------------------------------------------

    // Every field but pad random; the caller overwrites the ones the command uses,
    // so the unused bits still toggle.
    function automatic t_src_item noise_fields();
        logic [95:0] raw;
        t_src_item   it;
        raw = {$urandom(), $urandom(), $urandom()};
        it = raw[IN_TDATA_W-1:0];
        it.pad = '0;
        return it;
    endfunction

    function automatic logic [VOL_W-1:0] pick_volume();
        case ($urandom_range(0, 7))
            0:       return '0;         // track skipped
            1:       return '1;
            default: return VOL_W'($urandom_range(1, 255));
        endcase
    endfunction

    function automatic logic signed [SAMP_W-1:0] pick_sample();
        case ($urandom_range(0, 11))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            3:       return 16'shFFFF;
            default: return SAMP_W'($urandom());
        endcase
    endfunction

    // Mostly rates near the device rate so repeat runs stay short;
    // now and then anything the field holds, zero included.
    function automatic logic [RATE_W-1:0] pick_rate();
        int unsigned base, r;
        base = (cur_rate == 0) ? 1 : cur_rate;
        case ($urandom_range(0, 6))
            0: r = base;
            1: r = base * $urandom_range(2, 5);
            2: r = base / $urandom_range(2, 5);
            3: r = $urandom_range(1, 192000);
            4: r = $urandom_range(0, 262143);
            5: r = base + $urandom_range(0, 999);
            default: begin
                case ($urandom_range(0, 5))
                    0: r = 0;
                    1: r = 8000;
                    2: r = 22050;
                    3: r = 48000;
                    4: r = 96000;
                    default: r = 192000;
                endcase
            end
        endcase
        if (r > 262143) r = 262143;
        return r[RATE_W-1:0];
    endfunction

    // ---------------------------------------------------------------
    // Sender: bursts of items with random gaps between them
    // ---------------------------------------------------------------

    task automatic send(input logic [CMD_W-1:0] cmd, input t_src_item it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = steady ? 0 : ($urandom_range(0, 5) == 0 ? $urandom_range(10, 60)
                                                        : $urandom_range(0, 6));
            if (gap != 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= it;
        i_s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    task automatic begin_track(input logic st, input logic [RATE_W-1:0] rate,
                               input logic [VOL_W-1:0] tv, input logic [VOL_W-1:0] sv);
        t_src_item it;
        it = noise_fields();
        it.source_stereo = st;
        it.source_rate = rate;
        it.track_volume = tv;
        it.sound_volume = sv;
        send(CMD_BEGIN, it);
    endtask

    task automatic source_frame(input logic signed [SAMP_W-1:0] l,
                                input logic signed [SAMP_W-1:0] r);
        t_src_item it;
        it = noise_fields();
        it.left_sample = l;
        it.right_sample = r;
        send(CMD_FRAME, it);
    endtask

    task automatic read_frame(input logic [IDX_W-1:0] idx);
        t_src_item it;
        it = noise_fields();
        it.frame_index = idx;
        send(CMD_READ, it);
    endtask

    // Drop valid, wait for every read result, then give the block time to
    // finish a repeat run that produces no result.
    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Setup then access; back-to-back writes keep psel high between them.
    task automatic apb_write(input t_reg_addr addr, input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        penable <= 1'b0;
    endtask

    // ---------------------------------------------------------------
    // Receiver: own stall pattern, plus a long hold-off on request
    // ---------------------------------------------------------------

    initial begin : result_side
        int run_left, mode, served;
        run_left = 0;
        mode = 0;
        served = 0;
        i_m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req != served) begin
                served = hold_req;
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                if (run_left == 0) begin
                    mode = $urandom_range(0, 3);
                    run_left = $urandom_range(4, 80);
                end
                run_left--;
                case (mode)
                    0:       i_m_axis_tready <= 1'b1;                       // never stalls
                    1:       i_m_axis_tready <= ($urandom_range(0, 3) != 0);
                    2:       i_m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: i_m_axis_tready <= run_left[2];                // periodic
                endcase
            end
        end
    end

    // ---------------------------------------------------------------
    // Watchdog: any handshake resets the count
    // ---------------------------------------------------------------

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready) || (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------

    initial begin : stimulus
        logic [RATE_W-1:0] rate;
        logic              dev_st;
        logic [BUFF_W-1:0] nfr;
        int                done, n_tracks, nf, nr, base;
        logic [VOL_W-1:0]  tv, sv;
        logic [CMD_W-1:0]  cmd;

        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        hold_req = 0;
        burst_left = 0;
        quiet_cycles = 0;
        steady = 1'b0;
        cur_rate = 44100;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, reset configuration: 44.1 kHz stereo, 1024 frames.
        // Buffer starts cleared: both ends read back zero.
        read_frame('0);
        read_frame(IDX_W'(FRAMES - 1));
        // Full gain stereo track at the device rate, sample extremes
        begin_track(1'b1, 44100, 8'd255, 8'd255);
        source_frame(16'sh7FFF, 16'sh8000);
        source_frame(16'sh8000, 16'sh7FFF);
        source_frame(16'sh0000, 16'shFFFF);     // -1 scales to -1 (floor)
        // Second pass on the same frames drives the sums into both clamps
        begin_track(1'b1, 44100, 8'd255, 8'd255);
        source_frame(16'sh7FFF, 16'sh7FFF);
        source_frame(16'sh8000, 16'sh8000);
        // Zero gain: the frame must leave the buffer untouched
        begin_track(1'b0, 44100, 8'd0, 8'd255);
        source_frame(16'sd1234, 16'sd1234);
        // Mono track at twice the device rate keeps every other frame
        begin_track(1'b0, 88200, 8'd128, 8'd200);
        source_frame(-16'sd300, 16'sd5);
        source_frame(16'sd7777, 16'sd0);
        source_frame(-16'sd1, 16'sd9);
        // Rate zero counts as one: one frame repeats up to the buffer end
        begin_track(1'b1, '0, 8'd255, 8'd1);
        source_frame(16'sh8000, 16'sh7FFF);
        // Unknown command
        send(CMD_NONE, noise_fields());
        // Highest rate the field holds: decimation by five
        begin_track(1'b1, '1, 8'd200, 8'd255);
        source_frame(16'sd100, -16'sd100);
        read_frame(10'd0);
        read_frame(10'd1);
        read_frame(10'd2);
        read_frame(10'd1023);
        read_frame(10'd512);

        // Backpressure: receiver holds off while reads keep coming, so the
        // output register fills and the input stalls behind it.
        hold_req <= hold_req + 1;
        repeat (8) read_frame(IDX_W'($urandom_range(0, FRAMES - 1)));
        settle();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            // Device settings, extremes first; zero rate and zero frames
            // exercise the degenerate paths.
            case (ph)
                0:       begin rate = 44100;  dev_st = 1'b1; nfr = 1024; end
                1:       begin rate = 1;      dev_st = 1'b0; nfr = 1;    end
                2:       begin rate = 192000; dev_st = 1'b1; nfr = 2047; end
                3:       begin rate = 0;      dev_st = 1'b1; nfr = 16;   end
                4:       begin rate = 48000;  dev_st = 1'b0; nfr = 1024; end
                5:       begin rate = 22050;  dev_st = 1'b1; nfr = 0;    end
                6: begin
                    rate = RATE_W'($urandom_range(1, 192000));
                    dev_st = 1'($urandom_range(0, 1));
                    nfr = BUFF_W'($urandom_range(1, 1024));
                end
                default: begin rate = 192000; dev_st = 1'b0; nfr = 1024; end
            endcase
            apb_write(REG_DEV_RATE, APB_DW'(rate));
            apb_write(REG_DEV_STEREO, APB_DW'(dev_st));
            apb_write(REG_BUF_FRAMES, APB_DW'(nfr));
            psel <= 1'b0;
            pwrite <= 1'b0;
            cur_rate = rate;
            steady = ($urandom_range(0, 3) == 0);

            done = 0;
            while (done < RAND_ITEMS / N_PHASES) begin
                if ($urandom_range(0, 9) == 0) steady = ~steady;
                if ($urandom_range(0, 4) != 0) begin
                    // Mixing pass: a few tracks over the same frames, then
                    // read back (and clear) a run of frames.
                    n_tracks = $urandom_range(1, 3);
                    repeat (n_tracks) begin
                        tv = pick_volume();
                        sv = pick_volume();
                        begin_track(1'($urandom_range(0, 1)), pick_rate(), tv, sv);
                        done++;
                        nf = $urandom_range(1, 20);
                        repeat (nf) begin
                            source_frame(pick_sample(), pick_sample());
                            done++;
                        end
                    end
                    nr = $urandom_range(1, 20);
                    base = ($urandom_range(0, 7) == 0) ? $urandom_range(0, FRAMES - 1) : 0;
                    for (int i = 0; i < nr; i++) begin
                        read_frame(IDX_W'((base + i) % FRAMES));
                        done++;
                    end
                end else begin
                    // Noise: any command with any field content
                    cmd = CMD_W'($urandom_range(0, 3));
                    send(cmd, noise_fields());
                    done++;
                end
            end
            settle();
        end

        if (mismatches == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
